FILE: design/hlpfp_pkg.sv
// Shared types, constants and the hex digit decoder for the hex frame parser.
// No dependencies.
package hlpfp_pkg;

   // Width of the saturating frame counter
   localparam int FRAME_COUNT_BITS = 16;

   // Result status codes
   localparam logic [1:0] STATUS_BYTE  = 2'd0;
   localparam logic [1:0] STATUS_CLEAN = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // ASCII characters used by the decoder
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] NIBBLE_TEN = 8'h0a;

   // One queue entry: a decoded byte, or the end marker with the dangling-nibble flag
   typedef struct packed {
      logic       eos;
      logic       dangling;
      logic [7:0] data;
   } q_entry_type;

   // Hex digit to nibble; anything that is not a hex digit decodes as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c - CHAR_0;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
         v = c - CHAR_LC_A + NIBBLE_TEN;
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
         v = c - CHAR_UC_A + NIBBLE_TEN;
      end
      return v[3:0];
   endfunction

endpackage

FILE: design/hlpfp_front.sv
// Front end: takes characters, pairs nibbles into bytes and pushes bytes and the
// end marker into the queue. Depends on hlpfp_pkg.
module hlpfp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_char_code,
   input  logic                     req_end_of_stream,
   input  logic                     q_full,
   output logic                     q_push,
   output hlpfp_pkg::q_entry_type   q_wdata
);
   import hlpfp_pkg::*;

   logic       pending_ff, pending_in;
   logic [3:0] high_ff, high_in;
   logic       done_ff, done_in;
   logic       accept;
   logic [3:0] nibble;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign nibble    = hex_value(req_char_code);

   // Nibble pairing and end-of-stream latch
   always_comb begin
      pending_in = pending_ff;
      high_in    = high_ff;
      done_in    = done_ff;
      q_push     = 1'b0;
      q_wdata    = '{eos: 1'b0, dangling: 1'b0, data: {high_ff, nibble}};
      if (accept && !done_ff) begin
         if (req_end_of_stream) begin
            q_push   = 1'b1;
            q_wdata  = '{eos: 1'b1, dangling: pending_ff, data: 8'h00};
            done_in  = 1'b1;
         end else if (pending_ff) begin
            q_push     = 1'b1;
            pending_in = 1'b0;
         end else begin
            high_in    = nibble;
            pending_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         high_ff    <= 4'h0;
         done_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         high_ff    <= high_in;
         done_ff    <= done_in;
      end
   end

endmodule

FILE: design/hlpfp_queue.sv
// Two-entry queue between front and back end, push and pop in the same cycle.
// Depends on hlpfp_pkg.
module hlpfp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_push,
   input  hlpfp_pkg::q_entry_type   q_wdata,
   output logic                     q_full,
   output logic                     q_valid,
   input  logic                     q_pop,
   output hlpfp_pkg::q_entry_type   q_rdata
);
   import hlpfp_pkg::*;

   q_entry_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign q_full  = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_rdata = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, q_push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/hlpfp_back.sv
// Back end: frame tracking on decoded bytes, result formation and output register.
// Depends on hlpfp_pkg.
module hlpfp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  hlpfp_pkg::q_entry_type   q_rdata,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_data_byte,
   output logic [15:0]              rsp_frame_number,
   output logic [16:0]              rsp_byte_position,
   output logic                     rsp_last_of_frame
);
   import hlpfp_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'b01,
      PH_PAYLOAD = 2'b10
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [7:0]                  len_hi_ff, len_hi_in;
   logic [15:0]                 remaining_ff, remaining_in;
   logic [16:0]                 pos_ff, pos_in;
   logic [FRAME_COUNT_BITS-1:0] frames_ff, frames_in;

   logic                        valid_ff, valid_in;
   logic [1:0]                  status_ff, status_in;
   logic [7:0]                  data_ff, data_in;
   logic [15:0]                 frame_ff, frame_in;
   logic [16:0]                 position_ff, position_in;
   logic                        last_ff, last_in;

   logic [31:0]                 frames_wide;
   logic [FRAME_COUNT_BITS-1:0] frames_next;
   logic [15:0]                 length;
   logic [15:0]                 rem_dec;
   logic                        clean;

   assign q_pop = q_valid && (!valid_ff || !rsp_stall);

   assign frames_wide = 32'(frames_ff);
   assign frames_next = (frames_ff == '1) ? frames_ff :
                        frames_ff + FRAME_COUNT_BITS'(1);
   assign length      = {len_hi_ff, q_rdata.data};
   assign rem_dec     = remaining_ff - 16'd1;
   assign clean       = (phase_ff == PH_HEADER) && !q_rdata.dangling &&
                        (pos_ff == 17'd0) && (frames_ff != '0);

   // Frame state and result formation for one popped entry
   always_comb begin
      phase_in     = phase_ff;
      len_hi_in    = len_hi_ff;
      remaining_in = remaining_ff;
      pos_in       = pos_ff;
      frames_in    = frames_ff;
      valid_in     = valid_ff && rsp_stall;
      status_in    = status_ff;
      data_in      = data_ff;
      frame_in     = frame_ff;
      position_in  = position_ff;
      last_in      = last_ff;
      if (q_pop) begin
         valid_in    = 1'b1;
         status_in   = STATUS_BYTE;
         data_in     = q_rdata.data;
         frame_in    = frames_wide[15:0];
         position_in = pos_ff;
         last_in     = 1'b0;
         if (q_rdata.eos) begin
            data_in = 8'h00;
            if (clean) begin
               status_in   = STATUS_CLEAN;
               position_in = 17'd0;
            end else begin
               status_in   = STATUS_ERROR;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (pos_ff == 17'd0) begin
                     len_hi_in = q_rdata.data;
                     pos_in    = 17'd1;
                  end else begin
                     remaining_in = length;
                     if (length == 16'd0) begin
                        last_in   = 1'b1;
                        frames_in = frames_next;
                        pos_in    = 17'd0;
                     end else begin
                        pos_in   = 17'd2;
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  remaining_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     last_in   = 1'b1;
                     frames_in = frames_next;
                     pos_in    = 17'd0;
                     phase_in  = PH_HEADER;
                  end else begin
                     pos_in = pos_ff + 17'd1;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         len_hi_ff    <= 8'h00;
         remaining_ff <= 16'h0000;
         pos_ff       <= 17'd0;
         frames_ff    <= '0;
         valid_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_hi_ff    <= len_hi_in;
         remaining_ff <= remaining_in;
         pos_ff       <= pos_in;
         frames_ff    <= frames_in;
         valid_ff     <= valid_in;
      end
   end

   // Output payload register, no reset
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      data_ff     <= data_in;
      frame_ff    <= frame_in;
      position_ff <= position_in;
      last_ff     <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_frame_number  = frame_ff;
   assign rsp_byte_position = position_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

FILE: design/hex_length_prefixed_frame_parser.sv
// Hex length-prefixed frame parser, top level: front end, two-entry queue, back end.
// A result is registered in two steps: the character or end marker that causes it is
// written into the queue, then the back end pops it into its output register.
// Throughput: one character per cycle while the queue is not full, set by the combinational
// nibble decode and the back end popping one queue entry per cycle unless the response stalls.
// Reset: synchronous, active high; clears all control state and frame counters.
module hex_length_prefixed_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_frame_number,
   output logic [16:0] rsp_byte_position,
   output logic        rsp_last_of_frame
);
   import hlpfp_pkg::*;

   logic        q_full;
   logic        q_push;
   logic        q_valid;
   logic        q_pop;
   q_entry_type q_wdata;
   q_entry_type q_rdata;

   hlpfp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_wdata           (q_wdata)
   );

   hlpfp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_rdata (q_rdata)
   );

   hlpfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_rdata           (q_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
